/* rtl/tma_pkg.sv */
`default_nettype none

package tma_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 8;
  localparam int AVG_W       = 32;
  localparam int WIN_W       = 7;

  // Running sum holds up to 127 full-scale samples
  localparam int SUM_W = SAMPLE_BITS + WIN_W;
  // Dividend is the sum magnitude scaled by the fraction bits
  localparam int DIV_W = SUM_W + FRAC_BITS;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in;
  } in_req_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] average;
    logic                    last_out;
  } out_req_t;

  // One queued division job
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [WIN_W-1:0]        fill;
    logic                    last;
  } job_t;

endpackage

`default_nettype wire

/* rtl/tma_front.sv */
`default_nettype none

module tma_front #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire tma_pkg::in_req_t in_req_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [tma_pkg::WIN_W-1:0] cfg_data_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output tma_pkg::job_t         push_data_o
);

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int AW    = ((PTR_W > tma_pkg::WIN_W) ? PTR_W : tma_pkg::WIN_W) + 1;
  localparam int CAP   = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
  localparam logic [tma_pkg::WIN_W-1:0] CAP_L   = tma_pkg::WIN_W'(CAP);
  localparam logic [PTR_W-1:0]          PTR_TOP = PTR_W'(MAX_WINDOW - 1);
  localparam logic [AW-1:0]             DEPTH_X = AW'(MAX_WINDOW);

  logic signed [tma_pkg::SAMPLE_BITS-1:0] ring_q [MAX_WINDOW];
  logic signed [tma_pkg::SAMPLE_BITS-1:0] rd_q;
  logic signed [tma_pkg::SAMPLE_BITS-1:0] smp_q;
  logic                                   last_q;
  logic                                   drop_q;

  logic                             pend_q, pend_d;
  logic [PTR_W-1:0]                 wp_q, wp_d;
  logic [tma_pkg::WIN_W-1:0]        fill_q, fill_d, fill_new;
  logic signed [tma_pkg::SUM_W-1:0] sum_q, sum_d, sum_new, sub_val;
  logic [tma_pkg::WIN_W-1:0]        len_q, len_d, eff_win;
  logic [AW-1:0]                    wp_x, win_x, idx_x;
  logic [PTR_W-1:0]                 old_idx;
  logic                             accept, drop;

  // Accept only when the previous item has been pushed and the queue has room
  assign in_stall_o = pend_q | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Clamp the window length to the usable range
  always_comb begin
    if (len_q == '0) begin
      eff_win = tma_pkg::WIN_W'(1);
    end else if (len_q > CAP_L) begin
      eff_win = CAP_L;
    end else begin
      eff_win = len_q;
    end
  end

  // Locate the sample that leaves the window
  assign wp_x    = AW'(wp_q);
  assign win_x   = AW'(eff_win);
  assign idx_x   = (wp_x >= win_x) ? (wp_x - win_x) : (wp_x + DEPTH_X - win_x);
  assign old_idx = idx_x[PTR_W-1:0];
  assign drop    = (fill_q >= eff_win);

  // Ring: write the new sample, read the oldest one before it is overwritten
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_q[wp_q] <= in_req_i.sample;
      rd_q         <= ring_q[old_idx];
      smp_q        <= in_req_i.sample;
      last_q       <= in_req_i.last_in;
      drop_q       <= drop;
    end
  end

  // Update sum and fill count in the cycle after accept
  assign sub_val  = drop_q ? tma_pkg::SUM_W'(rd_q) : '0;
  assign sum_new  = sum_q - sub_val + tma_pkg::SUM_W'(smp_q);
  assign fill_new = drop_q ? fill_q : (fill_q + tma_pkg::WIN_W'(1));

  assign push_o           = pend_q;
  assign push_data_o.sum  = sum_new;
  assign push_data_o.fill = fill_new;
  assign push_data_o.last = last_q;

  always_comb begin
    pend_d = accept;
    wp_d   = wp_q;
    sum_d  = sum_q;
    fill_d = fill_q;
    len_d  = len_q;
    if (accept) begin
      wp_d = (wp_q == PTR_TOP) ? '0 : (wp_q + PTR_W'(1));
    end
    if (cfg_valid_i) begin
      // Restart the window on any register write
      len_d  = cfg_data_i;
      sum_d  = '0;
      fill_d = '0;
    end else if (pend_q) begin
      if (last_q) begin
        sum_d  = '0;
        fill_d = '0;
      end else begin
        sum_d  = sum_new;
        fill_d = fill_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      wp_q   <= '0;
      sum_q  <= '0;
      fill_q <= '0;
      len_q  <= tma_pkg::WIN_RESET;
    end else begin
      pend_q <= pend_d;
      wp_q   <= wp_d;
      sum_q  <= sum_d;
      fill_q <= fill_d;
      len_q  <= len_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/tma_queue.sv */
`default_nettype none

module tma_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tma_pkg::job_t push_data_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               valid_o,
  output tma_pkg::job_t      data_o
);

  localparam int PTR_W = (tma_pkg::QDEPTH > 1) ? $clog2(tma_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(tma_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(tma_pkg::QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(tma_pkg::QDEPTH);

  tma_pkg::job_t    slot_q [tma_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_TOP);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_TOP) ? '0 : (wr_q + PTR_W'(1));
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_TOP) ? '0 : (rd_q + PTR_W'(1));
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tma_back.sv */
`default_nettype none

module tma_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire tma_pkg::job_t q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tma_pkg::out_req_t  out_req_o
);

  localparam int DW    = tma_pkg::DIV_W;
  localparam int WW    = tma_pkg::WIN_W;
  localparam int AW    = tma_pkg::AVG_W;
  localparam int CNT_W = $clog2(DW + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);
  localparam logic [DW:0]      NEG_LIM  = (DW + 1)'(1) << (AW - 1);
  localparam logic [DW:0]      POS_LIM  = NEG_LIM - (DW + 1)'(1);
  localparam logic [AW-1:0]    AVG_MAX  = {1'b0, {(AW - 1){1'b1}}};
  localparam logic [AW-1:0]    AVG_MIN  = {1'b1, {(AW - 1){1'b0}}};

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    div_q, div_d;
  logic [WW-1:0]    rem_q, rem_d;
  logic [WW-1:0]    den_q, den_d;
  logic             neg_q, neg_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  tma_pkg::out_req_t out_q, out_d;

  logic [tma_pkg::SUM_W-1:0] mag;
  logic [WW:0]   rem_sh, rem_sub;
  logic          ge;
  logic [DW:0]   q_adj;
  logic [AW-1:0] result;
  logic          out_free;

  assign pop_o       = (state_q == BK_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  // Magnitude of the incoming sum
  assign mag = q_data_i.sum[tma_pkg::SUM_W-1] ? (-q_data_i.sum) : q_data_i.sum;

  // One restoring division step
  assign rem_sh  = {rem_q, div_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = (rem_sh >= {1'b0, den_q});

  // Floor for negative sums, then saturate
  assign q_adj = {1'b0, div_q} + (DW + 1)'(neg_q && (rem_q != '0));
  always_comb begin
    if (neg_q) begin
      result = (q_adj > NEG_LIM) ? AVG_MIN : (AW'(0) - q_adj[AW-1:0]);
    end else begin
      result = (q_adj > POS_LIM) ? AVG_MAX : q_adj[AW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    div_d       = div_q;
    rem_d       = rem_q;
    den_d       = den_q;
    neg_d       = neg_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          div_d   = DW'(mag) << tma_pkg::FRAC_BITS;
          rem_d   = '0;
          den_d   = q_data_i.fill;
          neg_d   = q_data_i.sum[tma_pkg::SUM_W-1];
          last_d  = q_data_i.last;
          cnt_d   = '0;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_d = ge ? rem_sub[WW-1:0] : rem_sh[WW-1:0];
        div_d = {div_q[DW-2:0], ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        // Hold the result until the output register is free
        if (out_free) begin
          out_d.average  = result;
          out_d.last_out = last_q;
          out_valid_d    = 1'b1;
          state_d        = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/trailing_moving_average_unit.sv */
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  in_req_i  (sample, last_in)
// out      output     out_valid_o/out_stall_i out_req_o (average, last_out)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (window_len)
//
// From accept to a valid result the steps are: sum update, queue pop, 39
// restoring divide steps (one quotient bit a cycle) and the output load.
// The back works on one job at a time and loads its result before it pops another; the block holds up to four requests.
// Reset is asynchronous; the sample ring is not cleared, as only entries
// written since the last restart are read.
// A stalled result sits in the output register while the divider goes on.
`default_nettype none

module trailing_moving_average_unit #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire tma_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tma_pkg::out_req_t      out_req_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [tma_pkg::WIN_W-1:0] cfg_data_i
);

  logic          q_push, q_full, q_valid, q_pop, cfg_wr;
  tma_pkg::job_t push_data, q_data;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  tma_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_wr),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (push_data)
  );

  tma_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  tma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // Every accepted item is pushed in the following cycle
  a_push_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> q_push)
    else $error("accepted item not pushed");

  // Checks that the divisor handed to the back is never zero
  a_nonzero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_data.fill != '0))
    else $error("zero divisor popped");

endmodule

`default_nettype wire
